// File: rtl/core/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

// File: rtl/core/ibhpq_pkg.sv
`default_nettype none
package ibhpq_pkg;

  localparam int ID_W     = 8;
  localparam int ID_SLOTS = 256;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_ERASE  = 2'd2,
    FUNC_UPDATE = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/ibhpq_if.sv
`default_nettype none
// operation request channel
interface ibhpq_in_if #(
  parameter int KEY_WIDTH = 32
);
  import ibhpq_pkg::*;
  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [ID_W-1:0]      item_id;
  logic [KEY_WIDTH-1:0] key;
  modport source (output valid, func, item_id, key, input ready);
  modport sink   (input valid, func, item_id, key, output ready);
endinterface

// result channel
interface ibhpq_out_if #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 9
);
  import ibhpq_pkg::*;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [ID_W-1:0]      out_id;
  logic [KEY_WIDTH-1:0] out_key;
  logic [CNT_W-1:0]     count;
  logic                 front_valid;
  logic [ID_W-1:0]      front_id;
  logic [KEY_WIDTH-1:0] front_key;
  modport source (output valid, status, out_id, out_key, count, front_valid, front_id,
                  front_key, input ready);
  modport sink   (input valid, status, out_id, out_key, count, front_valid, front_id,
                  front_key, output ready);
endinterface

// order register write channel
interface ibhpq_cfg_if;
  logic valid;
  logic ready;
  logic order_max;
  modport source (output valid, order_max, input ready);
  modport sink   (input valid, order_max, output ready);
endinterface
`default_nettype wire

// File: rtl/core/indexed_binary_heap_pqueue.sv
`default_nettype none
// Indexed binary-heap priority queue of (id, key) entries with push, pop, erase by id and
// key update, min- or max-first by the order register. One operation is in work at a time;
// every heap read goes through the single read port of the heap RAM. A rejected request
// (empty, full, absent or duplicate id) goes straight to S_FRONT and S_FRONT_WAIT, where
// every operation ends. An accepted push climbs through S_UP and S_UP_CMP; pop, erase and
// update run their setup steps, then climb or descend level by level. At a capacity of 256
// the longest operation is a root update walking 8 levels down, and the sequencer returns
// to S_IDLE before it takes the next request.
// A new request is taken as soon as the sequencer is idle, even while the last result
// still waits in the output register. No clearing pass after reset is needed.
`include "assert_macros.svh"
module indexed_binary_heap_pqueue #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  ibhpq_in_if.sink    in_ch,
  ibhpq_out_if.source out_ch,
  ibhpq_cfg_if.sink   cfg
);
  import ibhpq_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = PW + 2;
  localparam int EW = KEY_WIDTH + ID_W;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_ROOT, S_POP_LAST, S_POS_RD, S_ER_KEY, S_ER_LAST, S_UPD_PAR,
    S_UP, S_UP_CMP, S_DOWN, S_DN_L, S_DN_R, S_DN_CMP, S_PLACE, S_FRONT, S_FRONT_WAIT
  } state_t;

  state_t               state;
  func_t                op;
  logic [ID_W-1:0]      id_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [EW-1:0]        cur;
  logic [EW-1:0]        child;
  logic [PW-1:0]        idx;
  logic [PW-1:0]        nxt;
  logic [KEY_WIDTH-1:0] rkey;
  logic [ID_W-1:0]      rid;
  status_t              st;
  logic [CW-1:0]        cnt;
  logic [ID_SLOTS-1:0]  queued;
  logic                 order_max;

  logic                 h_wen, h_ren, p_wen, p_ren;
  logic [PW-1:0]        h_waddr, h_raddr, p_wdata;
  logic [EW-1:0]        h_wdata, h_rdata;
  logic [ID_W-1:0]      p_waddr, p_raddr;
  logic [PW-1:0]        p_rdata;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 bet_ab, bet_ba;
  logic [CW-1:0]        cnt_m1;
  logic [PW-1:0]        last, par_idx, par_pos;
  logic [XW-1:0]        left_w, right_w, cnt_x;
  logic                 in_acc, out_free, out_load;

  ibhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .wen(h_wen), .waddr(h_waddr), .wdata(h_wdata),
    .ren(h_ren), .raddr(h_raddr), .rdata(h_rdata)
  );

  ibhpq_ram #(.WIDTH(PW), .DEPTH(ID_SLOTS)) u_pos (
    .clk(clk), .wen(p_wen), .waddr(p_waddr), .wdata(p_wdata),
    .ren(p_ren), .raddr(p_raddr), .rdata(p_rdata)
  );

  // index arithmetic
  assign cnt_m1  = cnt - CW'(1);
  assign last    = cnt_m1[PW-1:0];
  assign par_idx = (idx - PW'(1)) >> 1;
  assign par_pos = (p_rdata - PW'(1)) >> 1;
  assign left_w  = {1'b0, idx, 1'b1};
  assign right_w = left_w + XW'(1);
  assign cnt_x   = XW'(cnt);

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign out_free     = !out_ch.valid || out_ch.ready;
  assign out_load     = (state == S_FRONT_WAIT) && out_free;

  // shared key comparator, operands picked by step
  always_comb begin
    cmp_a = h_rdata[EW-1:ID_W];
    cmp_b = rkey;
    case (state)
      S_UPD_PAR: begin
        cmp_a = key_r;
        cmp_b = h_rdata[EW-1:ID_W];
      end
      S_UP_CMP: begin
        cmp_a = cur[EW-1:ID_W];
        cmp_b = h_rdata[EW-1:ID_W];
      end
      S_DN_R: begin
        cmp_b = child[EW-1:ID_W];
      end
      S_DN_CMP: begin
        cmp_a = child[EW-1:ID_W];
        cmp_b = cur[EW-1:ID_W];
      end
      default: begin
      end
    endcase
  end

  assign bet_ab = order_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
  assign bet_ba = order_max ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  // memory port control
  always_comb begin
    h_ren   = 1'b0;
    h_raddr = '0;
    h_wen   = 1'b0;
    h_waddr = idx;
    h_wdata = cur;
    p_ren   = 1'b0;
    p_raddr = in_ch.item_id;
    p_wen   = 1'b0;
    p_waddr = cur[ID_W-1:0];
    p_wdata = idx;
    case (state)
      S_IDLE: begin
        if (in_acc && cnt != '0) begin
          if (in_ch.func == FUNC_POP) begin
            h_ren = 1'b1;
          end else if (in_ch.func != FUNC_PUSH && queued[in_ch.item_id]) begin
            p_ren = 1'b1;
          end
        end
      end
      S_POP_ROOT: begin
        h_ren   = 1'b1;
        h_raddr = last;
      end
      S_POS_RD: begin
        if (op == FUNC_ERASE) begin
          h_ren   = 1'b1;
          h_raddr = p_rdata;
        end else if (p_rdata != '0) begin
          h_ren   = 1'b1;
          h_raddr = par_pos;
        end
      end
      S_ER_KEY: begin
        h_ren   = (idx != last);
        h_raddr = last;
      end
      S_UP: begin
        h_ren   = (idx != '0);
        h_raddr = par_idx;
      end
      S_UP_CMP: begin
        h_wen   = bet_ab;
        h_wdata = h_rdata;
        p_wen   = bet_ab;
        p_waddr = h_rdata[ID_W-1:0];
      end
      S_DOWN: begin
        h_ren   = (left_w < cnt_x);
        h_raddr = left_w[PW-1:0];
      end
      S_DN_L: begin
        h_ren   = (right_w < cnt_x);
        h_raddr = right_w[PW-1:0];
      end
      S_DN_CMP: begin
        h_wen   = bet_ab;
        h_wdata = child;
        p_wen   = bet_ab;
        p_waddr = child[ID_W-1:0];
      end
      S_PLACE: begin
        h_wen = 1'b1;
        p_wen = 1'b1;
      end
      S_FRONT: begin
        h_ren = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      queued       <= '0;
      order_max    <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        order_max <= cfg.order_max;
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op    <= in_ch.func;
            id_r  <= in_ch.item_id;
            key_r <= in_ch.key;
            cur   <= {in_ch.key, in_ch.item_id};
            rid   <= '0;
            rkey  <= '0;
            st    <= ST_OK;
            state <= S_FRONT;
            if (in_ch.func == FUNC_PUSH) begin
              if (queued[in_ch.item_id]) begin
                st <= ST_DUP;
              end else if (cnt == CW'(CAPACITY)) begin
                st <= ST_FULL;
              end else begin
                idx                    <= cnt[PW-1:0];
                cnt                    <= cnt + CW'(1);
                queued[in_ch.item_id]  <= 1'b1;
                state                  <= S_UP;
              end
            end else if (cnt == '0) begin
              st <= ST_EMPTY;
            end else if (in_ch.func == FUNC_POP) begin
              state <= S_POP_ROOT;
            end else if (!queued[in_ch.item_id]) begin
              st <= ST_ABSENT;
            end else begin
              state <= S_POS_RD;
            end
          end
        end
        S_POP_ROOT: begin
          rid                       <= h_rdata[ID_W-1:0];
          rkey                      <= h_rdata[EW-1:ID_W];
          queued[h_rdata[ID_W-1:0]] <= 1'b0;
          cnt                       <= cnt_m1;
          state                     <= S_POP_LAST;
        end
        S_POP_LAST: begin
          cur   <= h_rdata;
          idx   <= '0;
          state <= (cnt == '0) ? S_FRONT : S_DOWN;
        end
        S_POS_RD: begin
          idx <= p_rdata;
          if (op == FUNC_ERASE) begin
            state <= S_ER_KEY;
          end else begin
            state <= (p_rdata == '0) ? S_DOWN : S_UPD_PAR;
          end
        end
        S_ER_KEY: begin
          rid          <= id_r;
          rkey         <= h_rdata[EW-1:ID_W];
          cnt          <= cnt_m1;
          queued[id_r] <= 1'b0;
          state        <= (idx == last) ? S_FRONT : S_ER_LAST;
        end
        S_ER_LAST: begin
          cur <= h_rdata;
          if (bet_ab) begin
            state <= S_UP;
          end else if (bet_ba) begin
            state <= S_DOWN;
          end else begin
            state <= S_PLACE;
          end
        end
        S_UPD_PAR: begin
          if (bet_ab) begin
            state <= S_UP;
          end else if (bet_ba) begin
            state <= S_DOWN;
          end else begin
            state <= S_PLACE;
          end
        end
        S_UP: begin
          state <= (idx == '0) ? S_PLACE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (bet_ab) begin
            idx   <= par_idx;
            state <= S_UP;
          end else begin
            state <= S_PLACE;
          end
        end
        S_DOWN: begin
          state <= (left_w < cnt_x) ? S_DN_L : S_PLACE;
        end
        S_DN_L: begin
          child <= h_rdata;
          nxt   <= left_w[PW-1:0];
          state <= (right_w < cnt_x) ? S_DN_R : S_DN_CMP;
        end
        S_DN_R: begin
          if (bet_ab) begin
            child <= h_rdata;
            nxt   <= right_w[PW-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (bet_ab) begin
            idx   <= nxt;
            state <= S_DOWN;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          state <= S_FRONT;
        end
        S_FRONT: begin
          state <= S_FRONT_WAIT;
        end
        S_FRONT_WAIT: begin
          if (out_free) begin
            out_ch.status      <= st;
            out_ch.out_id      <= rid;
            out_ch.out_key     <= rkey;
            out_ch.count       <= cnt;
            out_ch.front_valid <= (cnt != '0);
            out_ch.front_id    <= (cnt != '0) ? h_rdata[ID_W-1:0] : '0;
            out_ch.front_key   <= (cnt != '0) ? h_rdata[EW-1:ID_W] : '0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `CHK_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(CAPACITY))
  `CHK_IMPL(a_queued_cnt, clk, rst, 1'b1, $countones(queued) == int'(cnt))
  `CHK_NEXT(a_push_grows, clk, rst, in_acc && in_ch.func == FUNC_PUSH && !queued[in_ch.item_id] && cnt != CW'(CAPACITY), cnt == $past(cnt) + CW'(1))
  `CHK_IMPL(a_front_flag, clk, rst, out_ch.valid, out_ch.front_valid == (out_ch.count != '0))

endmodule
`default_nettype wire

// File: rtl/core/ibhpq_ram.sv
`default_nettype none
module ibhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: dv/indexed_binary_heap_pqueue_tb.sv
module indexed_binary_heap_pqueue_tb;
  import ibhpq_pkg::*;

  localparam int  CAP        = 256;
  localparam int  CYCLE_CAP  = 900000;
  localparam int  SETTLE_CYC = 60;

  typedef struct {
    status_t     st;
    logic [7:0]  oid;
    logic [31:0] okey;
    logic [8:0]  cnt;
    logic        fv;
    logic [7:0]  fid;
    logic [31:0] fkey;
  } heap_res_t;

  typedef struct {
    func_t       f;
    logic [7:0]  id;
    logic [31:0] k;
    bit          has_st;
    status_t     st;
  } op_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ibhpq_in_if  #(.KEY_WIDTH(32))              in_ch();
  ibhpq_out_if #(.KEY_WIDTH(32), .CNT_W(9))   out_ch();
  ibhpq_cfg_if                                cfg();

  indexed_binary_heap_pqueue #(.CAPACITY(CAP), .KEY_WIDTH(32)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  always #2 clk = ~clk;

  // shadow heap state
  logic [31:0] shadow_key [CAP];
  logic [7:0]  shadow_id  [CAP];
  int          slot_of    [256];
  bit          is_queued  [256];
  int          n_entries;
  bit          serve_max;

  heap_res_t   pending_results[$];
  int          n_errors;
  int          n_results;
  int          n_sent;
  int          cycles;
  int          hold_off;
  bit          no_idle;
  int          op_seen [4];
  int          st_seen [5];
  int          max_depth;

  function automatic bit beats(logic [31:0] a, logic [31:0] b);
    return serve_max ? (a > b) : (a < b);
  endfunction

  function automatic void put_slot(int p, logic [31:0] k, logic [7:0] id);
    shadow_key[p] = k;
    shadow_id[p]  = id;
    slot_of[id]   = p;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] ka;
    logic [7:0]  ia;
    ka = shadow_key[a];
    ia = shadow_id[a];
    put_slot(a, shadow_key[b], shadow_id[b]);
    put_slot(b, ka, ia);
  endfunction

  function automatic void climb(int i);
    int par;
    while (i > 0) begin
      par = (i - 1) / 2;
      if (!beats(shadow_key[i], shadow_key[par])) break;
      swap_slots(i, par);
      i = par;
    end
  endfunction

  function automatic void descend(int i);
    int l, r, nx;
    while (1) begin
      l = 2 * i + 1;
      r = l + 1;
      if (l >= n_entries) break;
      nx = l;
      if (r < n_entries && beats(shadow_key[r], shadow_key[l])) nx = r;
      if (!beats(shadow_key[nx], shadow_key[i])) break;
      swap_slots(i, nx);
      i = nx;
    end
  endfunction

  // apply one operation to the shadow heap and return its result
  function automatic heap_res_t heap_apply(func_t f, logic [7:0] id, logic [31:0] k);
    heap_res_t   r;
    int          p;
    logic [31:0] mk, pk;
    r.st   = ST_OK;
    r.oid  = '0;
    r.okey = '0;
    if (f == FUNC_PUSH) begin
      if (is_queued[id]) r.st = ST_DUP;
      else if (n_entries >= CAP) r.st = ST_FULL;
      else begin
        put_slot(n_entries, k, id);
        is_queued[id] = 1'b1;
        n_entries++;
        climb(n_entries - 1);
      end
    end else if (n_entries == 0) begin
      r.st = ST_EMPTY;
    end else if (f == FUNC_POP) begin
      r.oid  = shadow_id[0];
      r.okey = shadow_key[0];
      n_entries--;
      if (n_entries > 0) begin
        put_slot(0, shadow_key[n_entries], shadow_id[n_entries]);
        descend(0);
      end
      is_queued[r.oid] = 1'b0;
    end else if (!is_queued[id]) begin
      r.st = ST_ABSENT;
    end else if (f == FUNC_ERASE) begin
      p      = slot_of[id];
      r.oid  = id;
      r.okey = shadow_key[p];
      n_entries--;
      is_queued[id] = 1'b0;
      if (p != n_entries) begin
        mk = shadow_key[n_entries];
        put_slot(p, mk, shadow_id[n_entries]);
        if (beats(mk, r.okey)) climb(p);
        else if (beats(r.okey, mk)) descend(p);
      end
    end else begin
      p = slot_of[id];
      shadow_key[p] = k;
      if (p == 0) descend(0);
      else begin
        pk = shadow_key[(p - 1) / 2];
        if (beats(k, pk)) climb(p);
        else if (beats(pk, k)) descend(p);
      end
    end
    r.cnt  = n_entries[8:0];
    r.fv   = (n_entries > 0);
    r.fid  = (n_entries > 0) ? shadow_id[0] : '0;
    r.fkey = (n_entries > 0) ? shadow_key[0] : '0;
    return r;
  endfunction

  function automatic void note_error();
    n_errors++;
  endfunction

  // offer one operation and record its expected result on acceptance
  task automatic send_op(func_t f, logic [7:0] id, logic [31:0] k,
                         bit has_st = 1'b0, status_t st = ST_OK);
    int        gap;
    heap_res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = f;
    in_ch.item_id = id;
    in_ch.key     = k;
    do @(posedge clk); while (!in_ch.ready);
    r = heap_apply(f, id, k);
    if (has_st && r.st != st) begin
      if (n_errors < 10)
        $display("directed status: func %0d id %0d expected %0d model gives %0d",
                 f, id, st, r.st);
      note_error();
      r.st = st;
    end
    op_seen[f]++;
    st_seen[r.st]++;
    if (n_entries > max_depth) max_depth = n_entries;
    pending_results.push_back(r);
    n_sent++;
    if (n_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  task automatic finish_send();
    in_ch.valid = 1'b0;
  endtask

  // write the order register once the queue of results has drained
  task automatic write_order(bit v);
    finish_send();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg.valid     = 1'b1;
    cfg.order_max = v;
    do @(posedge clk); while (!cfg.ready);
    serve_max = v;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic logic [31:0] draw_key();
    int m;
    m = $urandom_range(0, 9);
    if (m < 5) return $urandom_range(0, 15);
    if (m < 7) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_queued();
    return shadow_id[$urandom_range(0, n_entries - 1)];
  endfunction

  function automatic logic [7:0] pick_free();
    logic [7:0] id;
    id = 8'($urandom);
    if (n_entries >= 256) return id;
    while (is_queued[id]) id = 8'($urandom);
    return id;
  endfunction

  // mostly legal operations on live ids, some noise
  task automatic random_ops(int n);
    int          r, push_lim;
    func_t       f;
    logic [7:0]  id;
    repeat (n) begin
      r = $urandom_range(0, 99);
      push_lim = (n_entries < 8) ? 60 : (n_entries > 200 ? 20 : 35);
      if (r < push_lim) begin
        f  = FUNC_PUSH;
        id = ($urandom_range(0, 19) == 0 || n_entries == 0) ? 8'($urandom) : pick_free();
        if (n_entries > 0 && $urandom_range(0, 19) == 0) id = pick_queued();
      end else begin
        r = $urandom_range(0, 2);
        f = (r == 0) ? FUNC_POP : (r == 1) ? FUNC_ERASE : FUNC_UPDATE;
        id = (n_entries > 0 && $urandom_range(0, 6) != 0) ? pick_queued() : 8'($urandom);
      end
      send_op(f, id, draw_key());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    heap_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        if (n_errors < 10) $display("result with no transaction outstanding");
        note_error();
      end else begin
        e = pending_results.pop_front();
        if (out_ch.status !== e.st || out_ch.out_id !== e.oid || out_ch.out_key !== e.okey ||
            out_ch.count !== e.cnt || out_ch.front_valid !== e.fv ||
            out_ch.front_id !== e.fid || out_ch.front_key !== e.fkey) begin
          if (n_errors < 10) begin
            $display("mismatch #%0d exp st %0d id %0d key %h cnt %0d fv %0d fid %0d fkey %h",
                     n_results, e.st, e.oid, e.okey, e.cnt, e.fv, e.fid, e.fkey);
            $display("            got st %0d id %0d key %h cnt %0d fv %0d fid %0d fkey %h",
                     out_ch.status, out_ch.out_id, out_ch.out_key, out_ch.count,
                     out_ch.front_valid, out_ch.front_id, out_ch.front_key);
          end
          note_error();
        end
      end
    end
  end

  // result-side backpressure, with an optional long hold
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready = 1'b0;
        hold_off--;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        @(posedge clk);
        if (out_ch.valid) stall = no_idle ? 0 : $urandom_range(0, 12);
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  op_row_t dir_ops[] = '{
    '{FUNC_POP,    8'd0,   32'h0,         1'b1, ST_EMPTY},
    '{FUNC_ERASE,  8'd5,   32'h0,         1'b1, ST_EMPTY},
    '{FUNC_UPDATE, 8'd5,   32'h1,         1'b1, ST_EMPTY},
    '{FUNC_PUSH,   8'd0,   32'hFFFF_FFFF, 1'b1, ST_OK},
    '{FUNC_PUSH,   8'd255, 32'h0,         1'b1, ST_OK},
    '{FUNC_PUSH,   8'd0,   32'h5,         1'b1, ST_DUP},
    '{FUNC_ERASE,  8'd7,   32'h0,         1'b1, ST_ABSENT},
    '{FUNC_UPDATE, 8'd9,   32'h3,         1'b1, ST_ABSENT},
    '{FUNC_PUSH,   8'd128, 32'h0,         1'b0, ST_OK},
    '{FUNC_PUSH,   8'd1,   32'd100,       1'b0, ST_OK},
    '{FUNC_PUSH,   8'd2,   32'd50,        1'b0, ST_OK},
    '{FUNC_PUSH,   8'd3,   32'd50,        1'b0, ST_OK},
    '{FUNC_PUSH,   8'd4,   32'd7,         1'b0, ST_OK},
    '{FUNC_UPDATE, 8'd255, 32'd200,       1'b0, ST_OK},
    '{FUNC_UPDATE, 8'd1,   32'd1,         1'b0, ST_OK},
    '{FUNC_UPDATE, 8'd3,   32'd50,        1'b0, ST_OK},
    '{FUNC_ERASE,  8'd2,   32'h0,         1'b0, ST_OK},
    '{FUNC_ERASE,  8'd4,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_PUSH,   8'd170, 32'h5555_5555, 1'b0, ST_OK},
    '{FUNC_PUSH,   8'd85,  32'hAAAA_AAAA, 1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b0, ST_OK},
    '{FUNC_POP,    8'd0,   32'h0,         1'b1, ST_EMPTY}
  };

  // main sequence
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_PUSH;
    in_ch.item_id = '0;
    in_ch.key     = '0;
    cfg.valid     = 1'b0;
    cfg.order_max = 1'b0;
    n_entries = 0; serve_max = 1'b0; n_errors = 0; n_results = 0; n_sent = 0;
    cycles = 0; hold_off = 0; no_idle = 1'b0; max_depth = 0;
    foreach (is_queued[i]) is_queued[i] = 1'b0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (st_seen[i]) st_seen[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_order(1'b0);
    foreach (dir_ops[i])
      send_op(dir_ops[i].f, dir_ops[i].id, dir_ops[i].k, dir_ops[i].has_st, dir_ops[i].st);

    write_order(1'b1);
    random_ops(150);

    // fill every id while results are held back, then a duplicate push
    hold_off = 600;
    while (n_entries < 256) send_op(FUNC_PUSH, pick_free(), draw_key());
    send_op(FUNC_PUSH, 8'($urandom), draw_key(), 1'b1, ST_DUP);
    send_op(FUNC_UPDATE, pick_queued(), draw_key());
    send_op(FUNC_ERASE, pick_queued(), 32'h0);
    repeat (20) send_op(FUNC_POP, 8'($urandom), 32'h0);

    write_order(1'b0);
    random_ops(200);

    write_order(1'b1);
    random_ops(100);
    while (n_entries > 0) send_op(FUNC_POP, 8'($urandom), 32'h0);
    finish_send();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    $display("sent %0d transactions: push %0d pop %0d erase %0d update %0d, depth up to %0d",
             n_sent, op_seen[FUNC_PUSH], op_seen[FUNC_POP], op_seen[FUNC_ERASE],
             op_seen[FUNC_UPDATE], max_depth);
    $display("status mix ok %0d empty %0d absent %0d dup %0d, both orders, %0d errors",
             st_seen[ST_OK], st_seen[ST_EMPTY], st_seen[ST_ABSENT], st_seen[ST_DUP],
             n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ibhpq_pkg.sv
rtl/core/ibhpq_if.sv
rtl/core/ibhpq_ram.sv
rtl/core/indexed_binary_heap_pqueue.sv
dv/indexed_binary_heap_pqueue_tb.sv
